/* sv/nmeachk_pkg.sv */
package nmeachk_pkg;

	localparam int MAX_BODY_DEF = 96;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_F      = 8'h46;
	localparam logic [7:0] CH_W      = 8'h57;
	localparam logic [7:0] CH_V      = 8'h56;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_U      = 8'h55;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_B      = 8'h42;

	localparam int HEX_RADIX = 16;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_HEX1 = 2'd2,
		PH_HEX2 = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_OTHER = 3'd0,
		KIND_WIND  = 3'd1,
		KIND_TEMP  = 3'd2,
		KIND_HUMID = 3'd3,
		KIND_BARO  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_TOO_LONG = 2'd2,
		ST_BAD_HEX  = 2'd3
	} status_t;

	typedef struct packed {
		logic [3:0] kinds_seen;
		logic [7:0] received_sum;
		logic [7:0] computed_sum;
		status_t    status;
		kind_t      sentence_kind;
	} result_t;

	localparam int TDATA_W = 24;

	// bit 4 marks a valid digit, bits 3..0 hold its value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c - CH_ZERO;
			return {1'b1, v[3:0]};
		end
		if (c >= CH_A && c <= CH_F) begin
			v = c - CH_A + 8'd10;
			return {1'b1, v[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic kind_t kind_decode(input logic [7:0] a, input logic [7:0] b);
		if (a == CH_W && b == CH_V) return KIND_WIND;
		if (a == CH_T && b == CH_A) return KIND_TEMP;
		if (a == CH_H && b == CH_U) return KIND_HUMID;
		if (a == CH_M && b == CH_B) return KIND_BARO;
		return KIND_OTHER;
	endfunction

endpackage

/* sv/nmea_sentence_checker_unit.sv */
// Checks NMEA 0183 sentence checksums on a stream of received bytes. One byte
// is accepted in every cycle while the output buffer has room; the byte is
// registered and then updates the running XOR, the body count and the sentence
// phase, and the result of a byte that finishes or drops a sentence is held in
// the output register before it reaches the master side. A two-entry output
// buffer holds results while the master side stalls; the slave side stalls only
// once both entries are full. The kind travels in m_tuser, the checksum report in m_tdata.
module nmea_sentence_checker_unit #(
	parameter int MAX_BODY = nmeachk_pkg::MAX_BODY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // rx_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [nmeachk_pkg::TDATA_W-1:0]  m_tdata,  // status, computed_sum,
	                                                   // received_sum, kinds_seen
	output logic [2:0]                       m_tuser   // sentence_kind
);
	import nmeachk_pkg::*;

	localparam logic [6:0] BODY_LIMIT = 7'(MAX_BODY);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// sentence state
	phase_t     phase_q, phase_d;
	logic [7:0] xor_q, xor_d;
	logic [6:0] count_q, count_d;
	logic [7:0] char1_q, char1_d;
	logic [7:0] char2_q, char2_d;
	logic [4:0] high_q, high_d;
	logic [3:0] seen_q, seen_d;

	// output buffer
	logic    out_valid_q, skid_valid_q;
	result_t out_data_q, skid_data_q;

	logic    advance;
	logic    res_valid;
	result_t res;
	logic    pop;

	kind_t      kind;
	logic [4:0] low_dig;
	logic [7:0] rsum;
	status_t    sum_status;
	logic [3:0] seen_upd;

	assign s_tready = !valid_s1 || !skid_valid_q;
	assign advance  = valid_s1 && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// checksum decode for the closing digit
	always_comb begin
		kind     = kind_decode(char1_q, char2_q);
		low_dig  = hex_decode(byte_s1);
		rsum     = 8'((high_q[3:0] * HEX_RADIX) | {4'd0, low_dig[3:0]});
		seen_upd = seen_q;
		if (!high_q[4] || !low_dig[4]) begin
			sum_status = ST_BAD_HEX;
		end else if (rsum != xor_q) begin
			sum_status = ST_MISMATCH;
		end else begin
			sum_status = ST_VALID;
			unique case (kind)
				KIND_WIND:  seen_upd = seen_q | 4'b0001;
				KIND_TEMP:  seen_upd = seen_q | 4'b0010;
				KIND_HUMID: seen_upd = seen_q | 4'b0100;
				KIND_BARO:  seen_upd = seen_q | 4'b1000;
				default:    seen_upd = seen_q;
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		xor_d   = xor_q;
		count_d = count_q;
		char1_d = char1_q;
		char2_d = char2_q;
		high_d  = high_q;
		seen_d  = seen_q;
		if (advance) begin
			if (byte_s1 == CH_DOLLAR) begin
				phase_d = PH_BODY;
				xor_d   = 8'd0;
				count_d = 7'd0;
				char1_d = 8'd0;
				char2_d = 8'd0;
				high_d  = 5'd0;
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_BODY: begin
						if (byte_s1 == CH_STAR) begin
							phase_d = PH_HEX1;
						end else if (count_q >= BODY_LIMIT) begin
							phase_d = PH_IDLE;
						end else begin
							if (count_q == 7'd3) char1_d = byte_s1;
							if (count_q == 7'd4) char2_d = byte_s1;
							xor_d   = xor_q ^ byte_s1;
							count_d = count_q + 7'd1;
						end
					end
					PH_HEX1: begin
						high_d  = hex_decode(byte_s1);
						phase_d = PH_HEX2;
					end
					PH_HEX2: begin
						seen_d  = seen_upd;
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// result
	always_comb begin
		res_valid         = 1'b0;
		res.sentence_kind = kind;
		res.status        = sum_status;
		res.computed_sum  = xor_q;
		res.received_sum  = rsum;
		res.kinds_seen    = seen_upd;
		if (advance && byte_s1 != CH_DOLLAR) begin
			unique case (phase_q)
				PH_BODY: begin
					if (byte_s1 != CH_STAR && count_q >= BODY_LIMIT) begin
						res_valid        = 1'b1;
						res.status       = ST_TOO_LONG;
						res.received_sum = 8'd0;
						res.kinds_seen   = seen_q;
					end
				end
				PH_HEX2: res_valid = 1'b1;
				default: res_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			xor_q   <= 8'd0;
			count_q <= 7'd0;
			char1_q <= 8'd0;
			char2_q <= 8'd0;
			high_q  <= 5'd0;
			seen_q  <= 4'd0;
		end else begin
			phase_q <= phase_d;
			xor_q   <= xor_d;
			count_q <= count_d;
			char1_q <= char1_d;
			char2_q <= char2_d;
			high_q  <= high_d;
			seen_q  <= seen_d;
		end
	end

	// two-entry output buffer, oldest transaction in the main register
	assign pop = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= res_valid;
			end else begin
				out_valid_q  <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_data_q  <= skid_data_q;
				skid_data_q <= res;
			end else begin
				out_data_q  <= res;
			end
		end else if (res_valid) begin
			skid_data_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_data_q.sentence_kind;
	assign m_tdata  = TDATA_W'({out_data_q.kinds_seen, out_data_q.received_sum,
		out_data_q.computed_sum, out_data_q.status});

`ifndef NO_ASSERTIONS
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a transaction while main entry is empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= BODY_LIMIT)
		else $error("body count past limit");

	a_idle_needs_dollar: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE && !(advance && byte_s1 == CH_DOLLAR)) |=> phase_q == PH_IDLE)
		else $error("left idle without a dollar");

	a_valid_sets_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_VALID && res.sentence_kind == KIND_BARO)
		|=> seen_q[3])
		else $error("valid barometer sentence did not set its mask bit");
`endif

endmodule
